[hdl/ftcs_pkg.sv]
// shared types, codes and constants of the ftcs heat equation solver
package ftcs_pkg;

   localparam int CFG_W     = 16;
   localparam int STEP_W    = 16;
   localparam int NORM_W    = 16;
   localparam int SUM_W     = 48;
   localparam int SQRT_W    = SUM_W / 2;
   localparam int GAIN_FRAC = 16;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd3;

   // reset values of the configuration registers
   localparam logic [CFG_W-1:0] LEFT_RST  = 16'd23040;
   localparam logic [CFG_W-1:0] RIGHT_RST = 16'd17920;
   localparam logic [CFG_W-1:0] INIT_RST  = 16'd12800;
   localparam logic [CFG_W-1:0] GAIN_RST  = 16'd32768;

   // item function codes
   localparam logic FUNC_RUN  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_FILL,
      ST_SWEEP,
      ST_DRAIN,
      ST_BND_LEFT,
      ST_BND_RIGHT,
      ST_SQ_READ,
      ST_SQ_DRAIN,
      ST_DIV1,
      ST_LD_SQRT,
      ST_SQRT,
      ST_LD_DIV2,
      ST_DIV2,
      ST_FIN_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_run;
      logic load_read;
      logic fill_wr;
      logic rd_en;
      logic rd_node;
      logic rd_sweep;
      logic rd_square;
      logic wr_left;
      logic wr_right;
      logic div_load1;
      logic div_load2;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic res_read;
      logic res_run;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic busy;
   } stat_type;

endpackage

[hdl/ftcs_ctrl.sv]
// controller state machine of the ftcs heat equation solver
module ftcs_ctrl #(
   parameter int MAX_ZONES = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [ftcs_pkg::STEP_W-1:0]           req_step_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [$clog2(MAX_ZONES+1)-1:0]        zones,
   input  ftcs_pkg::stat_type                    stat,
   output ftcs_pkg::cmd_type                     cmd,
   output logic [$clog2(MAX_ZONES+1)-1:0]        addr
);

   localparam int AW = $clog2(MAX_ZONES + 1);
   localparam int CW = (AW > 6) ? AW : 6;
   localparam logic [ftcs_pkg::STEP_W-1:0] STEP_ONE = 1;

   ftcs_pkg::state_type                state_ff, state_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;
   logic [ftcs_pkg::STEP_W-1:0]        steps_ff, steps_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               last_node;

   assign last_node = (cnt_ff == CW'(zones));
   assign addr      = cnt_ff[AW-1:0];
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ftcs_pkg::ST_IDLE;
         cnt_ff       <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      steps_in  = steps_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ftcs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_valid) begin
               if (req_func == ftcs_pkg::FUNC_READ) begin
                  cmd.load_read = 1'b1;
                  state_in      = ftcs_pkg::ST_RD_ADDR;
               end else begin
                  cmd.load_run = 1'b1;
                  steps_in     = req_step_count;
                  state_in     = ftcs_pkg::ST_FILL;
               end
            end
         end
         ftcs_pkg::ST_RD_ADDR: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_node = 1'b1;
            state_in    = ftcs_pkg::ST_RD_DATA;
         end
         ftcs_pkg::ST_RD_DATA: begin
            cmd.res_read = 1'b1;
            state_in     = ftcs_pkg::ST_FINISH;
         end
         ftcs_pkg::ST_FILL: begin
            cmd.fill_wr = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (last_node) begin
               cnt_in   = '0;
               state_in = (steps_ff == '0) ? ftcs_pkg::ST_SQ_READ : ftcs_pkg::ST_SWEEP;
            end
         end
         ftcs_pkg::ST_SWEEP: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sweep = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last_node) begin
               cnt_in   = '0;
               state_in = ftcs_pkg::ST_DRAIN;
            end
         end
         ftcs_pkg::ST_DRAIN: begin
            if (!stat.busy) begin
               steps_in = steps_ff - 1'b1;
               state_in = (steps_ff == STEP_ONE) ? ftcs_pkg::ST_BND_LEFT
                                                 : ftcs_pkg::ST_SWEEP;
            end
         end
         ftcs_pkg::ST_BND_LEFT: begin
            cmd.wr_left = 1'b1;
            state_in    = ftcs_pkg::ST_BND_RIGHT;
         end
         ftcs_pkg::ST_BND_RIGHT: begin
            cmd.wr_right = 1'b1;
            state_in     = ftcs_pkg::ST_SQ_READ;
         end
         ftcs_pkg::ST_SQ_READ: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_square = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (last_node) begin
               cnt_in   = '0;
               state_in = ftcs_pkg::ST_SQ_DRAIN;
            end
         end
         ftcs_pkg::ST_SQ_DRAIN: begin
            if (!stat.busy) begin
               cmd.div_load1 = 1'b1;
               state_in      = ftcs_pkg::ST_DIV1;
            end
         end
         ftcs_pkg::ST_DIV1: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ftcs_pkg::SUM_W - 1)) begin
               cnt_in   = '0;
               state_in = ftcs_pkg::ST_LD_SQRT;
            end
         end
         ftcs_pkg::ST_LD_SQRT: begin
            cmd.sqrt_load = 1'b1;
            state_in      = ftcs_pkg::ST_SQRT;
         end
         ftcs_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ftcs_pkg::SQRT_W - 1)) begin
               cnt_in   = '0;
               state_in = ftcs_pkg::ST_LD_DIV2;
            end
         end
         ftcs_pkg::ST_LD_DIV2: begin
            cmd.div_load2 = 1'b1;
            state_in      = ftcs_pkg::ST_DIV2;
         end
         ftcs_pkg::ST_DIV2: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ftcs_pkg::SUM_W - 1)) begin
               cnt_in   = '0;
               state_in = ftcs_pkg::ST_FIN_RUN;
            end
         end
         ftcs_pkg::ST_FIN_RUN: begin
            cmd.res_run = 1'b1;
            state_in    = ftcs_pkg::ST_FINISH;
         end
         ftcs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ftcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ftcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending one");

   // sweeps only run while steps remain
   a_sweep_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ftcs_pkg::ST_SWEEP) |-> (steps_ff != '0))
      else $error("sweep with no step left");

   // node sweeps never address past the last node
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && !cmd.rd_node) |-> (cnt_ff <= CW'(zones)))
      else $error("sweep address beyond last node");

endmodule

[hdl/ftcs_dp.sv]
// datapath of the ftcs heat equation solver: grid memory, stencil, norm units
module ftcs_dp #(
   parameter int MAX_ZONES   = 256,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [ftcs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ftcs_pkg::CFG_W-1:0]            csr_wdata,
   input  logic [$clog2(MAX_ZONES+1)-1:0]        req_zone_count,
   input  logic [$clog2(MAX_ZONES+1)-1:0]        req_node_index,
   input  ftcs_pkg::cmd_type                     cmd,
   input  logic [$clog2(MAX_ZONES+1)-1:0]        addr,
   output ftcs_pkg::stat_type                    stat,
   output logic [$clog2(MAX_ZONES+1)-1:0]        zones,
   output logic signed [VALUE_WIDTH-1:0]         rsp_node_value,
   output logic [ftcs_pkg::NORM_W-1:0]           rsp_norm,
   output logic                                  rsp_index_error
);

   localparam int VW   = VALUE_WIDTH;
   localparam int AW   = $clog2(MAX_ZONES + 1);
   localparam int EW   = (VW > ftcs_pkg::CFG_W) ? VW : ftcs_pkg::CFG_W;
   localparam int LW   = VW + 2;
   localparam int PW   = LW + ftcs_pkg::CFG_W + 1;
   localparam int SW   = ftcs_pkg::SUM_W;
   localparam int ACCW = ((2 * VW > SW) ? 2 * VW : SW) + 1;
   localparam int QW   = ftcs_pkg::SQRT_W;
   localparam int RW   = QW + 3;
   localparam int NW   = ftcs_pkg::NORM_W;
   localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};

   // config value into node range, saturating when nodes are narrower
   function automatic logic signed [VW-1:0] to_val(input logic [ftcs_pkg::CFG_W-1:0] c);
      logic signed [EW-1:0] e;
      logic signed [EW-1:0] hi;
      logic signed [EW-1:0] lo;
      e  = EW'(signed'(c));
      hi = EW'((64'sd1 <<< (VW - 1)) - 64'sd1);
      lo = -hi - EW'(1);
      if (e > hi) begin
         return hi[VW-1:0];
      end else if (e < lo) begin
         return lo[VW-1:0];
      end
      return e[VW-1:0];
   endfunction

   logic [ftcs_pkg::CFG_W-1:0] left_ff, right_ff, init_ff, gain_ff;
   logic signed [VW-1:0]       left_v, right_v, init_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= ftcs_pkg::LEFT_RST;
         right_ff <= ftcs_pkg::RIGHT_RST;
         init_ff  <= ftcs_pkg::INIT_RST;
         gain_ff  <= ftcs_pkg::GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            ftcs_pkg::CSR_LEFT:  left_ff  <= csr_wdata;
            ftcs_pkg::CSR_RIGHT: right_ff <= csr_wdata;
            ftcs_pkg::CSR_INIT:  init_ff  <= csr_wdata;
            ftcs_pkg::CSR_GAIN:  gain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign left_v  = to_val(left_ff);
   assign right_v = to_val(right_ff);
   assign init_v  = to_val(init_ff);

   // item fields
   logic [AW-1:0] zones_ff, idx_ff, zc_clamp;

   always_comb begin
      zc_clamp = req_zone_count;
      if (req_zone_count < AW'(2)) begin
         zc_clamp = AW'(2);
      end else if (req_zone_count > AW'(MAX_ZONES)) begin
         zc_clamp = AW'(MAX_ZONES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zones_ff <= '0;
      end else if (cmd.load_run) begin
         zones_ff <= zc_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_read) begin
         idx_ff <= req_node_index;
      end
   end

   assign zones = zones_ff;

   // grid memory
   logic signed [VW-1:0] mem [0:MAX_ZONES];
   logic signed [VW-1:0] rd_data_ff;
   logic [AW-1:0]        ra;
   logic                 we;
   logic [AW-1:0]        wa;
   logic signed [VW-1:0] wd;
   logic signed [VW-1:0] upd_val;
   logic                 pvld_ff;
   logic [AW-1:0]        wa_ff;

   assign ra = cmd.rd_node ? idx_ff : addr;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[ra];
      end
   end

   always_comb begin
      we = 1'b0;
      wa = addr;
      wd = upd_val;
      if (cmd.fill_wr) begin
         we = 1'b1;
         wd = init_v;
      end else if (cmd.wr_left) begin
         we = 1'b1;
         wa = '0;
         wd = left_v;
      end else if (cmd.wr_right) begin
         we = 1'b1;
         wa = zones_ff;
         wd = right_v;
      end else if (pvld_ff) begin
         we = 1'b1;
         wa = wa_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
   end

   // stencil pipeline: read, gain multiply, round and write back
   logic                 rvld_ff, svld_ff;
   logic [AW-1:0]        raddr_ff;
   logic signed [VW-1:0] node_v;
   logic signed [VW-1:0] xp_ff, xc_ff, cur_ff;
   logic signed [LW-1:0] lap;
   logic signed [PW-1:0] prod_in, prod_ff, delta;
   logic signed [PW:0]   upd_sum;
   logic signed [PW:0]   val_hi, val_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         rvld_ff <= 1'b0;
         svld_ff <= 1'b0;
         pvld_ff <= 1'b0;
      end else begin
         rvld_ff <= cmd.rd_sweep;
         svld_ff <= cmd.rd_square;
         pvld_ff <= rvld_ff && (raddr_ff >= AW'(2));
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff <= addr;
   end

   always_comb begin
      if (raddr_ff == '0) begin
         node_v = left_v;
      end else if (raddr_ff == zones_ff) begin
         node_v = right_v;
      end else begin
         node_v = rd_data_ff;
      end
   end

   assign lap     = LW'(xp_ff) - (LW'(xc_ff) <<< 1) + LW'(node_v);
   assign prod_in = PW'(lap) * PW'($signed({1'b0, gain_ff}));

   always_ff @(posedge clock) begin
      if (rvld_ff) begin
         xp_ff   <= xc_ff;
         xc_ff   <= node_v;
         cur_ff  <= xc_ff;
         prod_ff <= prod_in;
         wa_ff   <= raddr_ff - 1'b1;
      end
   end

   assign delta   = (prod_ff + PW'(64'sd1 <<< (ftcs_pkg::GAIN_FRAC - 1)))
                    >>> ftcs_pkg::GAIN_FRAC;
   assign upd_sum = (PW + 1)'(cur_ff) + (PW + 1)'(delta);
   assign val_hi  = (PW + 1)'((64'sd1 <<< (VW - 1)) - 64'sd1);
   assign val_lo  = -val_hi - (PW + 1)'(1);

   always_comb begin
      if (upd_sum > val_hi) begin
         upd_val = val_hi[VW-1:0];
      end else if (upd_sum < val_lo) begin
         upd_val = val_lo[VW-1:0];
      end else begin
         upd_val = upd_sum[VW-1:0];
      end
   end

   // sum of squares
   logic [VW-1:0]     mag;
   logic [2*VW-1:0]   sq_ff;
   logic              sqv_ff;
   logic [SW-1:0]     sum_ff;
   logic [ACCW-1:0]   acc;

   assign mag = rd_data_ff[VW-1] ? VW'(-rd_data_ff) : VW'(rd_data_ff);
   assign acc = ACCW'(sum_ff) + ACCW'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sqv_ff <= 1'b0;
      end else begin
         sqv_ff <= svld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (svld_ff) begin
         sq_ff <= mag * mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.load_run) begin
         sum_ff <= '0;
      end else if (sqv_ff) begin
         sum_ff <= (acc > ACCW'(SUM_MAX)) ? SUM_MAX : acc[SW-1:0];
      end
   end

   assign stat.busy = rvld_ff | pvld_ff | svld_ff | sqv_ff;

   // restoring divider by the zone count, one quotient bit per cycle
   logic [SW-1:0] dq_ff;
   logic [AW:0]   drem_ff, drem_sh;
   logic          dge;
   logic [QW-1:0] root_ff;

   assign drem_sh = {drem_ff[AW-1:0], dq_ff[SW-1]};
   assign dge     = (drem_sh >= {1'b0, zones_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load1) begin
         dq_ff   <= sum_ff;
         drem_ff <= '0;
      end else if (cmd.div_load2) begin
         dq_ff   <= SW'(root_ff);
         drem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff   <= {dq_ff[SW-2:0], dge};
         drem_ff <= dge ? (drem_sh - {1'b0, zones_ff}) : drem_sh;
      end
   end

   // digit by digit square root, two radicand bits per cycle
   logic [SW-1:0] rad_ff;
   logic [RW-1:0] srem_ff, srem_t, strial;
   logic          sge;

   assign srem_t = {srem_ff[RW-3:0], rad_ff[SW-1:SW-2]};
   assign strial = RW'({root_ff, 2'b01});
   assign sge    = (srem_t >= strial);

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         rad_ff  <= dq_ff;
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[SW-3:0], 2'b00};
         srem_ff <= sge ? (srem_t - strial) : srem_t;
         root_ff <= {root_ff[QW-2:0], sge};
      end
   end

   // result staging and output registers
   logic signed [VW-1:0] pend_node_ff, rsp_node_ff;
   logic [NW-1:0]        pend_norm_ff, rsp_norm_ff;
   logic                 pend_err_ff, rsp_err_ff;
   logic                 idx_err;

   assign idx_err = (idx_ff > zones_ff);

   always_ff @(posedge clock) begin
      if (cmd.res_read) begin
         pend_node_ff <= idx_err ? '0 : rd_data_ff;
         pend_err_ff  <= idx_err;
         pend_norm_ff <= '0;
      end else if (cmd.res_run) begin
         pend_node_ff <= '0;
         pend_err_ff  <= 1'b0;
         pend_norm_ff <= (|dq_ff[SW-1:NW]) ? {NW{1'b1}} : dq_ff[NW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_node_ff <= pend_node_ff;
         rsp_norm_ff <= pend_norm_ff;
         rsp_err_ff  <= pend_err_ff;
      end
   end

   assign rsp_node_value  = rsp_node_ff;
   assign rsp_norm        = rsp_norm_ff;
   assign rsp_index_error = rsp_err_ff;

   // stencil write-back only touches interior nodes
   a_interior_wr: assert property (@(posedge clock) disable iff (reset)
      pvld_ff |-> (wa_ff != '0) && (wa_ff < zones_ff))
      else $error("stencil write outside interior");

   // at most one write source per cycle
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.fill_wr, cmd.wr_left, cmd.wr_right, pvld_ff}))
      else $error("memory write conflict");

   // the divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> (drem_ff < {1'b0, zones_ff}))
      else $error("divider remainder out of range");

endmodule

[hdl/heat_equation_explicit_solver.sv]
// top level of the explicit ftcs 1-d heat equation solver
//
//  channel  ports            direction  carries
//  req      req_valid/ready  in         func, zone_count, step_count, node_index
//  rsp      rsp_valid/ready  out        node_value, norm, index_error
//  csr      csr_we           in         register index and write data, no read-back
//
//  read item: the node is read from the grid memory, staged, then loaded into the output register
//  run item: fill, one sweep per time step, 2 boundary writes (when steps > 0),
//    square sum, divide by the zone count, square root, divide by it again; the grid
//    memory read port visits every node once per time step and sets the rate
//  one item at a time; a finished result waits in the output register while
//    the next item is accepted, and the block only stalls when it must overwrite it
//  synchronous active-high reset clears control state and loads the config registers with their reset values
module heat_equation_explicit_solver #(
   parameter int MAX_ZONES   = 256,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // item input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [$clog2(MAX_ZONES+1)-1:0]        req_zone_count,
   input  logic [ftcs_pkg::STEP_W-1:0]           req_step_count,
   input  logic [$clog2(MAX_ZONES+1)-1:0]        req_node_index,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]         rsp_node_value,
   output logic [ftcs_pkg::NORM_W-1:0]           rsp_norm,
   output logic                                  rsp_index_error,
   // configuration writes
   input  logic                                  csr_we,
   input  logic [ftcs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ftcs_pkg::CFG_W-1:0]            csr_wdata
);

   // commands from the controller, status back from the datapath
   ftcs_pkg::cmd_type                  cmd;
   ftcs_pkg::stat_type                 stat;
   logic [$clog2(MAX_ZONES+1)-1:0]     addr;
   logic [$clog2(MAX_ZONES+1)-1:0]     zones;

   // sequencer: fill, step sweeps, norm units, result handoff
   ftcs_ctrl #(
      .MAX_ZONES (MAX_ZONES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_step_count (req_step_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .zones          (zones),
      .stat           (stat),
      .cmd            (cmd),
      .addr           (addr)
   );

   // grid memory, stencil pipeline, divider and square root
   ftcs_dp #(
      .MAX_ZONES   (MAX_ZONES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_zone_count  (req_zone_count),
      .req_node_index  (req_node_index),
      .cmd             (cmd),
      .addr            (addr),
      .stat            (stat),
      .zones           (zones),
      .rsp_node_value  (rsp_node_value),
      .rsp_norm        (rsp_norm),
      .rsp_index_error (rsp_index_error)
   );

endmodule
